>>> src/hdrb_pkg.sv
// Shared types and constants for the IPv4 TCP/UDP header builder.
// Used by hdrb_csum, hdrb_assemble and ipv4_tcp_udp_header_builder; no dependencies.
package hdrb_pkg;

    localparam int unsigned IP_WORDS = 10;
    localparam int unsigned HDR_WORDS = 5;

    localparam logic [7:0]  VER_IHL    = 8'h45;
    localparam logic [7:0]  IP_TOS     = 8'h00;
    localparam logic [15:0] IP_FLAG_DF = 16'h4000;
    localparam logic [7:0]  IP_TTL     = 8'd64;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [15:0] IP_HDR_LEN = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;
    localparam logic [15:0] TCP_IP_LEN = 16'd40;
    localparam logic [7:0]  TCP_DOFF   = 8'h50;
    localparam logic [15:0] TCP_WINDOW = 16'hFFFF;
    localparam logic [7:0]  TCP_SYN_ONLY = 8'h02;
    localparam logic [5:0]  HLEN_TCP   = 6'd40;
    localparam logic [5:0]  HLEN_UDP   = 6'd28;

    typedef enum logic {
        CMD_TCP = 1'b0,
        CMD_UDP = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [15:0] payload_len;
        logic [7:0]  tcp_flag_bits;
        logic [31:0] sequence_number;
        logic [31:0] ack_number;
    } t_req;

    typedef struct packed {
        logic [5:0]                    header_length;
        logic [HDR_WORDS-1:0][63:0]    header_word;
    } t_rsp;

endpackage

>>> src/hdrb_csum.sv
// One's-complement checksum over the ten 16-bit words of an IPv4 header.
// Uses hdrb_pkg for the word count.
module hdrb_csum
    import hdrb_pkg::*;
(
    input  logic [IP_WORDS-1:0][15:0] i_words,
    output logic [15:0]               o_csum
);

    logic [16:0] s01, s23, s45, s67, s89;
    logic [17:0] s0123, s4567;
    logic [18:0] s_lo;
    logic [19:0] s_all;
    logic [16:0] fold1;
    logic [16:0] fold2;

    assign s01   = {1'b0, i_words[0]} + {1'b0, i_words[1]};
    assign s23   = {1'b0, i_words[2]} + {1'b0, i_words[3]};
    assign s45   = {1'b0, i_words[4]} + {1'b0, i_words[5]};
    assign s67   = {1'b0, i_words[6]} + {1'b0, i_words[7]};
    assign s89   = {1'b0, i_words[8]} + {1'b0, i_words[9]};
    assign s0123 = {1'b0, s01} + {1'b0, s23};
    assign s4567 = {1'b0, s45} + {1'b0, s67};
    assign s_lo  = {1'b0, s0123} + {1'b0, s4567};
    assign s_all = {1'b0, s_lo} + {3'b000, s89};

    assign fold1  = {1'b0, s_all[15:0]} + {13'd0, s_all[19:16]};
    assign fold2  = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    assign o_csum = ~fold2[15:0];

endmodule

>>> src/hdrb_assemble.sv
// Builds the IPv4 plus TCP or UDP header words for one request.
// Uses hdrb_pkg and the checksum unit hdrb_csum.
module hdrb_assemble
    import hdrb_pkg::*;
(
    input  t_req        i_req,
    input  logic [15:0] i_ident,
    output t_rsp        o_rsp
);

    logic        is_udp;
    logic [15:0] udp_len;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [31:0] ack_eff;
    logic [15:0] csum;
    logic [IP_WORDS-1:0][15:0] ip_words;

    assign is_udp    = (i_req.cmd == CMD_UDP);
    assign udp_len   = UDP_HDR_LEN + i_req.payload_len;
    assign total_len = is_udp ? (IP_HDR_LEN + udp_len) : (TCP_IP_LEN + i_req.payload_len);
    assign proto     = is_udp ? PROTO_UDP : PROTO_TCP;
    assign ack_eff   = (i_req.tcp_flag_bits == TCP_SYN_ONLY) ? 32'd0 : i_req.ack_number;

    assign ip_words[0] = {VER_IHL, IP_TOS};
    assign ip_words[1] = total_len;
    assign ip_words[2] = i_ident;
    assign ip_words[3] = IP_FLAG_DF;
    assign ip_words[4] = {IP_TTL, proto};
    assign ip_words[5] = 16'd0;
    assign ip_words[6] = i_req.source_address[31:16];
    assign ip_words[7] = i_req.source_address[15:0];
    assign ip_words[8] = i_req.dest_address[31:16];
    assign ip_words[9] = i_req.dest_address[15:0];

    hdrb_csum u_csum (
        .i_words (ip_words),
        .o_csum  (csum)
    );

    always_comb begin
        o_rsp.header_word[0] = {VER_IHL, IP_TOS, total_len, i_ident, IP_FLAG_DF};
        o_rsp.header_word[1] = {IP_TTL, proto, csum, i_req.source_address};
        o_rsp.header_word[2] = {i_req.dest_address, i_req.source_port, i_req.dest_port};
        if (is_udp) begin
            o_rsp.header_word[3] = {udp_len, 16'd0, 32'd0};
            o_rsp.header_word[4] = 64'd0;
            o_rsp.header_length  = HLEN_UDP;
        end else begin
            o_rsp.header_word[3] = {i_req.sequence_number, ack_eff};
            o_rsp.header_word[4] = {TCP_DOFF, i_req.tcp_flag_bits, TCP_WINDOW, 32'd0};
            o_rsp.header_length  = HLEN_TCP;
        end
    end

endmodule

>>> src/ipv4_tcp_udp_header_builder.sv
// Top level of the IPv4 TCP/UDP header builder: input register, identification counter,
// header assembly and result register. Uses hdrb_pkg and hdrb_assemble.
//
//  Channel | Direction | Contents
//  s_*     | in        | one packet descriptor per request; tuser carries the TCP/UDP select
//  m_*     | out       | five big-endian header words and the header length
//
// An accepted request waits in the input register, then moves to the result register;
// one request is accepted per cycle while the result side keeps up. The pipeline
// is the input register followed by the result register. Reset clears both valid flags
// and the identification counter. A stall on the result side holds both stages; the input
// side still takes a request while the input stage is empty.
module ipv4_tcp_udp_header_builder
    import hdrb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // source_address, source_port, dest_address, dest_port, payload_len,
    // tcp_flag_bits, sequence_number, ack_number
    input  logic [183:0] i_s_tdata,
    // cmd
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // header_word_0 .. header_word_4, header_length, two zero bits
    output logic [327:0] o_m_tdata
);

    logic        r_in_valid, n_in_valid;
    t_req        r_in, n_in;
    logic        r_out_valid, n_out_valid;
    t_rsp        r_out, n_out;
    logic [15:0] r_ident, n_ident;

    logic        out_free;
    logic        advance;
    logic        take_in;
    t_req        req_in;
    t_rsp        rsp;

    assign req_in.cmd             = t_cmd'(i_s_tuser[0]);
    assign req_in.source_address  = i_s_tdata[31:0];
    assign req_in.source_port     = i_s_tdata[47:32];
    assign req_in.dest_address    = i_s_tdata[79:48];
    assign req_in.dest_port       = i_s_tdata[95:80];
    assign req_in.payload_len     = i_s_tdata[111:96];
    assign req_in.tcp_flag_bits   = i_s_tdata[119:112];
    assign req_in.sequence_number = i_s_tdata[151:120];
    assign req_in.ack_number      = i_s_tdata[183:152];

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign take_in    = i_s_tvalid && o_s_tready;

    hdrb_assemble u_assemble (
        .i_req   (r_in),
        .i_ident (r_ident),
        .o_rsp   (rsp)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in        = r_in;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_ident     = r_ident;
        if (out_free) begin
            n_out_valid = r_in_valid;
        end
        if (advance) begin
            n_out = rsp;
            if (r_in.cmd == CMD_TCP) begin
                n_ident = r_ident + 16'd1;
            end
        end
        if (take_in) begin
            n_in_valid = 1'b1;
            n_in       = req_in;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ident     <= 16'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_ident     <= n_ident;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out};

endmodule
